// ===== rtl/core/infix_to_postfix_converter_defines.svh =====
// assertion macros used by the checker file
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define I2P_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define I2P_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/i2p_pkg.sv =====
`default_nettype none

package i2p_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_POP,
        S_END
    } t_state;

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_MISMATCH = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_ALNUM,
        CLS_OPENER,
        CLS_OPERATOR,
        CLS_CLOSER
    } t_cls;

    // stack symbol codes, operators below the openers
    typedef enum logic [2:0] {
        SYM_PLUS,
        SYM_MINUS,
        SYM_STAR,
        SYM_SLASH,
        SYM_CARET,
        SYM_PAREN,
        SYM_BRACKET,
        SYM_BRACE
    } t_sym;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UPR_LO = 8'h41;
    localparam logic [7:0] CH_UPR_HI = 8'h5A;
    localparam logic [7:0] CH_LWR_LO = 8'h61;
    localparam logic [7:0] CH_LWR_HI = 8'h7A;
    localparam logic [7:0] CH_NONE   = 8'h00;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= CH_DIG_LO && c <= CH_DIG_HI) ||
               (c >= CH_UPR_LO && c <= CH_UPR_HI) ||
               (c >= CH_LWR_LO && c <= CH_LWR_HI);
    endfunction

    function automatic t_cls classify(input logic [7:0] c);
        t_cls cls;
        case (c)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: cls = CLS_OPERATOR;
            CH_LPAREN, CH_LBRACK, CH_LBRACE:                cls = CLS_OPENER;
            CH_RPAREN, CH_RBRACK, CH_RBRACE:                cls = CLS_CLOSER;
            default: begin
                cls = is_alnum(c) ? CLS_ALNUM : CLS_OTHER;
            end
        endcase
        return cls;
    endfunction

    // closers map to the code of their opener
    function automatic t_sym sym_of(input logic [7:0] c);
        t_sym s;
        case (c)
            CH_PLUS:              s = SYM_PLUS;
            CH_MINUS:             s = SYM_MINUS;
            CH_STAR:              s = SYM_STAR;
            CH_SLASH:             s = SYM_SLASH;
            CH_CARET:             s = SYM_CARET;
            CH_LPAREN, CH_RPAREN: s = SYM_PAREN;
            CH_LBRACK, CH_RBRACK: s = SYM_BRACKET;
            CH_LBRACE, CH_RBRACE: s = SYM_BRACE;
            default:              s = SYM_PLUS;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] sym_char(input t_sym s);
        logic [7:0] c;
        case (s)
            SYM_PLUS:    c = CH_PLUS;
            SYM_MINUS:   c = CH_MINUS;
            SYM_STAR:    c = CH_STAR;
            SYM_SLASH:   c = CH_SLASH;
            SYM_CARET:   c = CH_CARET;
            SYM_PAREN:   c = CH_LPAREN;
            SYM_BRACKET: c = CH_LBRACK;
            SYM_BRACE:   c = CH_LBRACE;
            default:     c = CH_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] prec(input t_sym s);
        logic [2:0] p;
        case (s)
            SYM_PLUS, SYM_MINUS: p = 3'd2;
            SYM_STAR, SYM_SLASH: p = 3'd3;
            SYM_CARET:           p = 3'd4;
            default:             p = 3'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/infix_to_postfix_converter.sv =====
`default_nettype none

// Shunting-yard infix to postfix converter. One ASCII character enters per input beat,
// i_end_of_expr flags the last one. Letters and digits come out at once; + - * / ^ are
// stacked with precedences 2, 2, 3, 3, 4, all left-associative, and ( [ { must be closed
// by their own closer. Each output beat carries a postfix character (kind 0), an
// expression-done mark (kind 1), a bracket mismatch (kind 2) or a stack overflow
// (kind 3); o_last_of_run marks the last beat caused by one input character. After an
// error, input is dropped silently up to and including the next flagged character.
// Stack access: the operator stack lives in a single-port-per-side synchronous memory
// with a registered read, so every look at the top of stack passes through a read state
// and an evaluate state. A letter, digit, ignored character or opener needs no look; an
// operator or closer takes one look plus one for each operator it pops; a flagged
// character that raises no error adds one look plus one per operator left on the stack.
// A dropped character is taken in the idle state; downstream stall stretches the rest.
// There is no clearing pass after reset: the stack is tracked by its fill count.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // character input
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_end_of_expr,
    // postfix result output
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_ch,
    output logic [1:0]      o_kind,
    output logic            o_last_of_run
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(STACK_DEPTH);

    // control state
    i2p_pkg::t_state r_state;
    i2p_pkg::t_state n_state;
    logic [CW-1:0]   r_count;
    logic            r_skip;      // dropping input after an error
    logic            r_err;       // current character raised an error
    logic            r_flush;     // popping the rest at end of expression
    logic            r_pend_valid;
    logic            r_out_valid;

    // current character, decoded
    i2p_pkg::t_sym   r_code;
    logic            r_is_closer;
    logic            r_last;

    // stack memory and its registered read port
    i2p_pkg::t_sym   r_stack_mem [STACK_DEPTH];
    i2p_pkg::t_sym   r_top;

    // one result held back until we know whether it ends the run
    logic [7:0]      r_pend_ch;
    i2p_pkg::t_kind  r_pend_kind;

    logic [7:0]      r_out_ch;
    i2p_pkg::t_kind  r_out_kind;
    logic            r_out_last;

    // decode of the arriving character
    i2p_pkg::t_cls   in_cls;
    i2p_pkg::t_sym   in_code;
    logic            in_fire;

    // top-of-stack evaluation
    logic            stack_full;
    logic            stack_empty;
    logic            top_is_op;
    logic            pop_op;
    logic            top_match;
    logic [CW-1:0]   count_m1;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;

    // actions of this cycle
    logic            emit;
    logic [7:0]      emit_ch;
    i2p_pkg::t_kind  emit_kind;
    logic            push;
    i2p_pkg::t_sym   push_code;
    logic            pop;
    logic            set_err;
    logic            finish;
    logic            slot_free;
    logic            hold;
    logic            load_out;

    assign in_cls  = i2p_pkg::classify(i_ch);
    assign in_code = i2p_pkg::sym_of(i_ch);
    assign in_fire = (r_state == i2p_pkg::S_IDLE) && i_in_valid;

    assign stack_full  = (r_count == COUNT_FULL);
    assign stack_empty = (r_count == '0);
    assign count_m1    = r_count - CW'(1);
    assign rd_addr     = count_m1[AW-1:0];
    assign wr_addr     = r_count[AW-1:0];
    assign top_is_op   = (r_top < i2p_pkg::SYM_PAREN);

    // operators pop on precedence, closers and the final flush pop any operator
    assign pop_op = !stack_empty && top_is_op &&
                    (r_flush || r_is_closer ||
                     (i2p_pkg::prec(r_top) >= i2p_pkg::prec(r_code)));
    assign top_match = !stack_empty && (r_top == r_code);

    // a new result may enter the holding slot once the older one can move out
    assign slot_free = !r_out_valid || !i_out_stall;
    assign hold      = emit && r_pend_valid && !slot_free;

    // actions per state
    always_comb begin
        emit      = 1'b0;
        emit_ch   = i2p_pkg::CH_NONE;
        emit_kind = i2p_pkg::KIND_CHAR;
        push      = 1'b0;
        push_code = in_code;
        pop       = 1'b0;
        set_err   = 1'b0;
        finish    = 1'b0;
        case (r_state)
            i2p_pkg::S_IDLE: begin
                if (in_fire && !r_skip) begin
                    case (in_cls)
                        i2p_pkg::CLS_ALNUM: begin
                            emit    = 1'b1;
                            emit_ch = i_ch;
                        end
                        i2p_pkg::CLS_OPENER: begin
                            if (stack_full) begin
                                emit      = 1'b1;
                                emit_kind = i2p_pkg::KIND_OVERFLOW;
                                set_err   = 1'b1;
                            end else begin
                                push = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            i2p_pkg::S_POP: begin
                push_code = r_code;
                if (pop_op) begin
                    emit    = 1'b1;
                    emit_ch = i2p_pkg::sym_char(r_top);
                    pop     = 1'b1;
                end else if (r_flush) begin
                    // an opener left on the stack is unclosed
                    emit      = 1'b1;
                    emit_kind = stack_empty ? i2p_pkg::KIND_DONE : i2p_pkg::KIND_MISMATCH;
                end else if (r_is_closer) begin
                    if (top_match) begin
                        pop = 1'b1;
                    end else begin
                        emit      = 1'b1;
                        emit_kind = i2p_pkg::KIND_MISMATCH;
                        set_err   = 1'b1;
                    end
                end else if (stack_full) begin
                    emit      = 1'b1;
                    emit_kind = i2p_pkg::KIND_OVERFLOW;
                    set_err   = 1'b1;
                end else begin
                    push = 1'b1;
                end
            end
            i2p_pkg::S_END: begin
                finish = !r_pend_valid || slot_free;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            i2p_pkg::S_IDLE: begin
                if (in_fire && !r_skip) begin
                    case (in_cls)
                        i2p_pkg::CLS_OPERATOR, i2p_pkg::CLS_CLOSER: n_state = i2p_pkg::S_READ;
                        i2p_pkg::CLS_OPENER: begin
                            n_state = (stack_full || !i_end_of_expr) ? i2p_pkg::S_END
                                                                     : i2p_pkg::S_READ;
                        end
                        default: begin
                            n_state = i_end_of_expr ? i2p_pkg::S_READ : i2p_pkg::S_END;
                        end
                    endcase
                end
            end
            i2p_pkg::S_READ: begin
                n_state = i2p_pkg::S_POP;
            end
            i2p_pkg::S_POP: begin
                if (hold) begin
                    n_state = i2p_pkg::S_POP;
                end else if (pop_op) begin
                    n_state = i2p_pkg::S_READ;
                end else if (r_flush || set_err || !r_last) begin
                    n_state = i2p_pkg::S_END;
                end else begin
                    n_state = i2p_pkg::S_READ;
                end
            end
            i2p_pkg::S_END: begin
                if (finish) begin
                    n_state = i2p_pkg::S_IDLE;
                end
            end
            default: n_state = i2p_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= i2p_pkg::S_IDLE;
            r_count      <= '0;
            r_skip       <= 1'b0;
            r_err        <= 1'b0;
            r_flush      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // error flag of the character in progress
            if (!hold && set_err) begin
                r_err <= 1'b1;
            end else if (in_fire) begin
                r_err <= 1'b0;
            end

            if (in_fire) begin
                // characters that need no stack look go straight to the flush
                r_flush <= !((in_cls == i2p_pkg::CLS_OPERATOR) ||
                             (in_cls == i2p_pkg::CLS_CLOSER));
                if (r_skip && i_end_of_expr) begin
                    r_count <= '0;
                    r_skip  <= 1'b0;
                end
            end

            if (!hold) begin
                if (push) begin
                    r_count <= r_count + CW'(1);
                end else if (pop) begin
                    r_count <= count_m1;
                end
                if ((r_state == i2p_pkg::S_POP) && !pop_op && !r_flush && !set_err &&
                    r_last) begin
                    r_flush <= 1'b1;
                end
            end

            if (finish) begin
                if (r_last) begin
                    r_count <= '0;
                    r_skip  <= 1'b0;
                end else if (r_err) begin
                    r_skip <= 1'b1;
                end
            end

            // holding slot
            if (emit && !hold) begin
                r_pend_valid <= 1'b1;
            end else if (finish) begin
                r_pend_valid <= 1'b0;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // the held result moves out when a newer one replaces it or the run ends
    assign load_out = r_pend_valid && ((emit && !hold) || finish);

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_code      <= in_code;
            r_is_closer <= (in_cls == i2p_pkg::CLS_CLOSER);
            r_last      <= i_end_of_expr;
        end
        if (emit && !hold) begin
            r_pend_ch   <= emit_ch;
            r_pend_kind <= emit_kind;
        end
        if (load_out) begin
            r_out_ch   <= r_pend_ch;
            r_out_kind <= r_pend_kind;
            r_out_last <= finish;
        end
    end

    // stack memory: write on push, registered read of the top entry
    always_ff @(posedge i_clk) begin
        if (push && !hold) begin
            r_stack_mem[wr_addr] <= push_code;
        end
        if ((r_state == i2p_pkg::S_READ) && !stack_empty) begin
            r_top <= r_stack_mem[rd_addr];
        end
    end

    assign o_in_stall    = (r_state != i2p_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_ch      = r_out_ch;
    assign o_kind        = r_out_kind;
    assign o_last_of_run = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/i2p_checker.sv =====
`default_nettype none

`include "infix_to_postfix_converter_defines.svh"

module i2p_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_end_of_expr,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [7:0] i_out_ch,
    input  wire logic [1:0] i_kind,
    input  wire logic       i_last_of_run
);

    logic out_is_char;
    logic legal_char;

    assign out_is_char = (i_kind == i2p_pkg::KIND_CHAR);
    assign legal_char  = i2p_pkg::is_alnum(i_out_ch) ||
                         (i_out_ch == i2p_pkg::CH_PLUS)  || (i_out_ch == i2p_pkg::CH_MINUS) ||
                         (i_out_ch == i2p_pkg::CH_STAR)  || (i_out_ch == i2p_pkg::CH_SLASH) ||
                         (i_out_ch == i2p_pkg::CH_CARET);

    // stalled input beat holds
    `I2P_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, i_in_valid && i_in_stall, i_in_valid && $stable(i_ch) && $stable(i_end_of_expr), "stalled input beat changed")

    // stalled output beat holds
    `I2P_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_ch) && $stable(i_kind) && $stable(i_last_of_run), "stalled output beat changed")

    // status beats close the run and carry no character
    `I2P_ASSERT_IMP(a_status_last, i_clk, i_rst_n, i_out_valid && !out_is_char, i_last_of_run && (i_out_ch == i2p_pkg::CH_NONE), "status beat not final or carries a character")

    // postfix text holds only operands and operators, never a bracket
    `I2P_ASSERT_IMP(a_char_legal, i_clk, i_rst_n, i_out_valid && out_is_char, legal_char, "illegal postfix character")

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .i_in_stall    (o_in_stall),
    .i_ch          (i_ch),
    .i_end_of_expr (i_end_of_expr),
    .i_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .i_out_ch      (o_out_ch),
    .i_kind        (o_kind),
    .i_last_of_run (o_last_of_run)
);

`default_nettype wire
